// ----- rtl/pfx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfx_pkg;

  // ASCII codes of the characters the evaluator acts on.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DEC   = 11'b000_0000_0010,
    S_RDB   = 11'b000_0000_0100,
    S_RDA   = 11'b000_0000_1000,
    S_SETUP = 11'b000_0001_0000,
    S_EXEC  = 11'b000_0010_0000,
    S_WB    = 11'b000_0100_0000,
    S_TAIL  = 11'b000_1000_0000,
    S_RDT   = 11'b001_0000_0000,
    S_EMIT  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/pfx_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/postfix_expression_evaluator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Beat contents
// in       into       in_valid/in_ready   symbol[7:0], last
// out      out of     out_valid/out_ready value[7:0] (signed), status[1:0]
//
// One input beat is taken when the sequencer is idle. An ignored character and a
// digit pass through decode and tail; an operator reads b and a, computes and writes
// back, with eight restoring steps on the trial subtractor for division and two
// passes of the shared 8x8 multiplier per exponent bit for ^; a last beat also reads
// the top of a non-empty stack and waits while the output register is still full.
// Reset clears the stack count, the sticky status and the output valid flag.
// A stalled output holds the sequencer in its emit state; the stack lives in one RAM.

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [7:0]        symbol,
  input  wire logic              last,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic signed [7:0] value,
  output      logic [1:0]        status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  pfx_pkg::state_t state;

  // Control registers.
  logic [CW-1:0] count;
  logic [1:0]    sticky;

  // Datapath registers.
  logic [7:0]        sym;
  logic              lst;
  logic signed [7:0] opb;
  logic [7:0]        acc;
  logic [7:0]        base;
  logic [6:0]        expo;
  logic [7:0]        rem;
  logic [7:0]        quo;
  logic [2:0]        iter;
  logic              phase;
  logic              neg;
  logic [7:0]        res;

  // Stack memory signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Shared 8x8 multiplier and a 9-bit trial subtractor for division.
  logic [7:0]  mul_x;
  logic [7:0]  mul_y;
  logic [15:0] prod;
  logic [8:0]  trial;
  logic        fits;
  logic [8:0]  diff;
  logic [7:0]  q_new;

  logic signed [7:0] a_in;
  logic              is_digit;
  logic              is_op;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  assign in_ready = (state == pfx_pkg::S_IDLE);

  pfx_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Character class of the held symbol.
  assign is_digit = (sym >= pfx_pkg::CH_0) && (sym <= pfx_pkg::CH_9);
  assign is_op = (sym == pfx_pkg::CH_PLUS) || (sym == pfx_pkg::CH_MINUS) ||
                 (sym == pfx_pkg::CH_STAR) || (sym == pfx_pkg::CH_SLASH) ||
                 (sym == pfx_pkg::CH_CARET) || (sym == pfx_pkg::CH_GT) ||
                 (sym == pfx_pkg::CH_LT) || (sym == pfx_pkg::CH_EQ) ||
                 (sym == pfx_pkg::CH_AMP) || (sym == pfx_pkg::CH_BAR);

  assign a_in = $signed(ram_rdata);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_x = ram_rdata;
    mul_y = opb;
    if (state == pfx_pkg::S_EXEC) begin
      if (!phase) begin
        mul_x = acc;
        mul_y = base;
      end else begin
        mul_x = base;
        mul_y = base;
      end
    end
  end

  assign prod = mul_x * mul_y;

  // One restoring division step; base holds the divisor magnitude.
  assign trial = {rem, quo[7]};
  assign fits  = trial >= {1'b0, base};
  assign diff  = trial - {1'b0, base};
  assign q_new = {quo[6:0], fits};

  // Stack memory access by state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = sym - pfx_pkg::CH_0;
    ram_re    = 1'b0;
    ram_raddr = cnt_m1[AW-1:0];
    case (state)
      pfx_pkg::S_DEC: begin
        ram_we = is_digit && (count < CW'(STACK_DEPTH));
      end
      pfx_pkg::S_RDB: begin
        ram_re = 1'b1;
      end
      pfx_pkg::S_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[AW-1:0];
      end
      pfx_pkg::S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = acc;
      end
      pfx_pkg::S_TAIL: begin
        ram_re = lst && (count != '0);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfx_pkg::S_IDLE;
      count     <= '0;
      sticky    <= pfx_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != pfx_pkg::S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        pfx_pkg::S_IDLE: begin
          if (in_valid) begin
            sym   <= symbol;
            lst   <= last;
            state <= pfx_pkg::S_DEC;
          end
        end

        // Push a digit, start an operator, or pass over anything else.
        pfx_pkg::S_DEC: begin
          state <= pfx_pkg::S_TAIL;
          if (is_digit) begin
            if (count < CW'(STACK_DEPTH)) begin
              count <= count + CW'(1);
            end else if (sticky == pfx_pkg::ST_OK) begin
              sticky <= pfx_pkg::ST_OVER;
            end
          end else if (is_op) begin
            if (count < CW'(2)) begin
              if (sticky == pfx_pkg::ST_OK) begin
                sticky <= pfx_pkg::ST_UNDER;
              end
            end else begin
              state <= pfx_pkg::S_RDB;
            end
          end
        end

        pfx_pkg::S_RDB: begin
          state <= pfx_pkg::S_RDA;
        end

        // Read data now holds b.
        pfx_pkg::S_RDA: begin
          opb   <= $signed(ram_rdata);
          state <= pfx_pkg::S_SETUP;
        end

        // Read data now holds a; finish short operators or set up iterations.
        pfx_pkg::S_SETUP: begin
          state <= pfx_pkg::S_WB;
          case (sym)
            pfx_pkg::CH_PLUS:  acc <= a_in + opb;
            pfx_pkg::CH_MINUS: acc <= a_in - opb;
            pfx_pkg::CH_STAR:  acc <= prod[7:0];
            pfx_pkg::CH_GT:    acc <= {7'd0, a_in > opb};
            pfx_pkg::CH_LT:    acc <= {7'd0, a_in < opb};
            pfx_pkg::CH_EQ:    acc <= {7'd0, a_in == opb};
            pfx_pkg::CH_AMP:   acc <= {7'd0, (a_in != 8'sd0) && (opb != 8'sd0)};
            pfx_pkg::CH_CARET: begin
              acc   <= 8'd1;
              base  <= ram_rdata;
              expo  <= opb[6:0];
              phase <= 1'b0;
              if (opb > 8'sd0) begin
                state <= pfx_pkg::S_EXEC;
              end
            end
            pfx_pkg::CH_SLASH: begin
              if (opb == 8'sd0) begin
                acc <= 8'd0;
                if (sticky == pfx_pkg::ST_OK) begin
                  sticky <= pfx_pkg::ST_DIVZ;
                end
              end else begin
                quo   <= a_in[7] ? 8'(-a_in) : ram_rdata;
                base  <= opb[7] ? 8'(-opb) : opb;
                rem   <= 8'd0;
                iter  <= 3'd0;
                neg   <= a_in[7] ^ opb[7];
                state <= pfx_pkg::S_EXEC;
              end
            end
            default: acc <= {7'd0, (a_in != 8'sd0) || (opb != 8'sd0)};
          endcase
        end

        // Iterate: square-and-multiply for ^, restoring steps for /.
        pfx_pkg::S_EXEC: begin
          if (sym == pfx_pkg::CH_CARET) begin
            if (!phase) begin
              if (expo[0]) begin
                acc <= prod[7:0];
              end
              phase <= 1'b1;
            end else begin
              base  <= prod[7:0];
              expo  <= {1'b0, expo[6:1]};
              phase <= 1'b0;
              if (expo[6:1] == 6'd0) begin
                state <= pfx_pkg::S_WB;
              end
            end
          end else begin
            quo  <= q_new;
            rem  <= fits ? diff[7:0] : trial[7:0];
            iter <= iter + 3'd1;
            if (iter == 3'd7) begin
              acc   <= neg ? 8'(8'd0 - q_new) : q_new;
              state <= pfx_pkg::S_WB;
            end
          end
        end

        // Result replaces a; the stack shrinks by one.
        pfx_pkg::S_WB: begin
          count <= cnt_m1;
          state <= pfx_pkg::S_TAIL;
        end

        // End of the character; a last beat fetches the top.
        pfx_pkg::S_TAIL: begin
          if (!lst) begin
            state <= pfx_pkg::S_IDLE;
          end else if (count == '0) begin
            res <= 8'd0;
            if (sticky == pfx_pkg::ST_OK) begin
              sticky <= pfx_pkg::ST_UNDER;
            end
            state <= pfx_pkg::S_EMIT;
          end else begin
            state <= pfx_pkg::S_RDT;
          end
        end

        pfx_pkg::S_RDT: begin
          res   <= ram_rdata;
          state <= pfx_pkg::S_EMIT;
        end

        // Load the output register once it is free, then clear the expression.
        pfx_pkg::S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= $signed(res);
            status    <= sticky;
            count     <= '0;
            sticky    <= pfx_pkg::ST_OK;
            state     <= pfx_pkg::S_IDLE;
          end
        end

        default: begin
          state <= pfx_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
